@@ rtl/sfr_pkg.sv @@
package sfr_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int REPLACE_MAX_DEF = 8;
  localparam int QUEUE_DEPTH     = 2;
  localparam int BUNDLE_BYTES    = 8;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } sfr_reg_t;

  // Work for the back end: up to eight bytes to send, in order, first byte low.
  // A zero count on a final request means a bare end marker.
  typedef struct packed {
    logic [BUNDLE_BYTES*8-1:0] bytes;
    logic [3:0]                count;
    logic                      fin;
  } sfr_bundle_t;

endpackage

@@ rtl/sfr_front.sv @@
module sfr_front #(
  parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                in_valid,
  input  logic [7:0]          in_data_byte,
  input  logic                in_final_byte,
  output logic                in_ready,
  input  logic                q_ready,
  output logic                q_push,
  output sfr_pkg::sfr_bundle_t q_data
);
  import sfr_pkg::*;

  localparam int FILL_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [3:0] PMAX = 4'(PATTERN_MAX);
  localparam logic [3:0] RMAX = 4'(REPLACE_MAX);

  logic [63:0]       pat_bytes_r;
  logic [3:0]        pat_len_r;
  logic [63:0]       rep_bytes_r;
  logic [3:0]        rep_len_r;
  logic [7:0]        win_r   [PATTERN_MAX];
  logic [7:0]        win_nxt [PATTERN_MAX];
  logic [7:0]        win_new [PATTERN_MAX];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [3:0]        plen;
  logic [3:0]        rlen;
  logic [3:0]        nf;
  logic              in_fire;
  logic              match;
  logic [63:0]       win_bytes;

  assign in_ready = q_ready;
  assign in_fire  = in_valid && q_ready;
  assign plen     = (pat_len_r > PMAX) ? PMAX : pat_len_r;
  assign rlen     = (rep_len_r > RMAX) ? RMAX : rep_len_r;
  assign nf       = 4'(fill_r) + 4'd1;

  always_comb begin
    // place the new byte behind the held ones
    for (int i = 0; i < PATTERN_MAX; i++) begin
      win_new[i] = (4'(i) == 4'(fill_r)) ? in_data_byte : win_r[i];
    end
    match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((4'(i) < plen) && (win_new[i] != pat_bytes_r[i*8 +: 8])) begin
        match = 1'b0;
      end
    end
    win_bytes = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      win_bytes[i*8 +: 8] = win_new[i];
    end
  end

  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    q_data   = '{bytes: win_bytes, count: 4'd0, fin: in_final_byte};
    if (plen == 4'd0) begin
      q_data.bytes = {56'd0, in_data_byte};
      q_data.count = 4'd1;
    end else if (nf == plen) begin
      if (match) begin
        q_data.bytes = rep_bytes_r;
        q_data.count = rlen;
        fill_nxt     = '0;
      end else begin
        q_data.count = in_final_byte ? nf : 4'd1;
        fill_nxt     = fill_r;
        for (int i = 0; i < PATTERN_MAX; i++) begin
          win_nxt[i] = (i + 1 < PATTERN_MAX) ? win_new[(i + 1) % PATTERN_MAX] : win_new[i];
        end
      end
    end else begin
      q_data.count = in_final_byte ? nf : 4'd0;
      win_nxt      = win_new;
      fill_nxt     = FILL_W'(nf);
    end
    if (in_final_byte) begin
      fill_nxt = '0;
    end
  end

  assign q_push = in_fire && ((q_data.count != 4'd0) || in_final_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= '0;
      rep_bytes_r <= '0;
      rep_len_r   <= '0;
      fill_r      <= '0;
    end else begin
      // a pattern length write drops whatever the window holds
      if (cfg_valid && (sfr_reg_t'(cfg_index) == REG_PATTERN_LENGTH)) begin
        fill_r <= '0;
      end else if (in_fire) begin
        fill_r <= fill_nxt;
      end
      if (cfg_valid) begin
        unique case (sfr_reg_t'(cfg_index))
          REG_PATTERN_BYTES:      pat_bytes_r <= cfg_data;
          REG_PATTERN_LENGTH:     pat_len_r   <= cfg_data[3:0];
          REG_REPLACEMENT_BYTES:  rep_bytes_r <= cfg_data;
          REG_REPLACEMENT_LENGTH: rep_len_r   <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      win_r <= win_nxt;
    end
  end

  // window never holds a full pattern between requests
  a_fill_short: assert property (@(posedge clk) disable iff (!rst_n)
    (plen != 4'd0) |-> (4'(fill_r) < plen))
    else $error("window fill reached pattern length");

endmodule

@@ rtl/sfr_fifo.sv @@
module sfr_fifo #(
  parameter int DEPTH = sfr_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sfr_pkg::sfr_bundle_t push_data,
  output logic                 not_full,
  input  logic                 pop,
  output sfr_pkg::sfr_bundle_t pop_data,
  output logic                 not_empty
);
  import sfr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfr_bundle_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign not_full  = (cnt_r != CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

@@ rtl/sfr_back.sv @@
module sfr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  sfr_pkg::sfr_bundle_t q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_byte_valid,
  output logic                 out_end_of_text
);
  import sfr_pkg::*;

  logic                      busy_r;
  logic [BUNDLE_BYTES*8-1:0] bytes_r;
  logic [2:0]                pos_r;
  logic [3:0]                total_r;
  logic                      bv_r;
  logic                      fin_r;
  logic                      out_valid_r;
  logic [7:0]                out_byte_r;
  logic                      out_bv_r;
  logic                      out_eot_r;
  logic                      adv;
  logic                      emit;
  logic                      last;

  assign adv   = !out_valid_r || out_ready;
  assign emit  = adv && busy_r;
  assign last  = ((4'(pos_r) + 4'd1) == total_r);
  assign q_pop = q_valid && (!busy_r || (emit && last));

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_byte_valid  = out_bv_r;
  assign out_end_of_text = out_eot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= busy_r;
      end
      if (q_pop) begin
        busy_r <= 1'b1;
      end else if (emit && last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= bv_r ? bytes_r[7:0] : 8'd0;
      out_bv_r   <= bv_r;
      out_eot_r  <= fin_r && last;
    end
    if (q_pop) begin
      bytes_r <= q_data.bytes;
      pos_r   <= '0;
      total_r <= (q_data.count == 4'd0) ? 4'd1 : q_data.count;
      bv_r    <= (q_data.count != 4'd0);
      fin_r   <= q_data.fin;
    end else if (emit) begin
      bytes_r <= {8'd0, bytes_r[BUNDLE_BYTES*8-1:8]};
      pos_r   <= pos_r + 3'd1;
    end
  end

  a_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |-> out_end_of_text)
    else $error("bare marker without end of text");
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ((4'(pos_r) < total_r) && (total_r != 4'd0)))
    else $error("bundle position past its length");

endmodule

@@ rtl/stream_find_and_replace.sv @@
// Channel  | Direction | Ports                                          | Handshake
// ---------+-----------+------------------------------------------------+-----------------
// cfg      | in        | cfg_index[1:0], cfg_data[63:0]                 | cfg_valid/ready
// in       | in        | in_data_byte[7:0], in_final_byte               | in_valid/ready
// out      | out       | out_byte[7:0], out_byte_valid, out_end_of_text | out_valid/ready
//
// Takes one byte request per cycle; the window compare and update finish in the
// accepting cycle, so input rate is one request per cycle while the queue has room.
// Results leave at one per cycle while out_ready is high; a request that makes k
// results holds the output side until all k have left; the input stalls once two
// bundles are queued. Results pass the queue, bundle register and output register.
// Reset (rst_n low, synchronous) zeroes the configuration registers, empties the window,
// the queue and the output stage; data registers are not cleared. cfg_ready is always
// high; the user must write the port only while idle; the block does not enforce it.
module stream_find_and_replace #(
  parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_end_of_text
);
  import sfr_pkg::*;

  sfr_bundle_t push_data;
  sfr_bundle_t pop_data;
  logic        push;
  logic        pop;
  logic        q_not_full;
  logic        q_not_empty;

  // Configuration is taken every cycle.
  assign cfg_ready = 1'b1;

  // Front end: hold the window, compare against the pattern, and turn each
  // request into one bundle of bytes to send (or none while the window fills).
  sfr_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .in_ready      (in_ready),
    .q_ready       (q_not_full),
    .q_push        (push),
    .q_data        (push_data)
  );

  // Short queue: lets the front keep taking bytes while the back drains a
  // multi-byte replacement.
  sfr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .not_full  (q_not_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_not_empty)
  );

  // Back end: serialize each bundle into the registered output, one result
  // per cycle unless out_ready stalls, and tag the text's last result with end of text.
  sfr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_not_empty),
    .q_data          (pop_data),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_end_of_text (out_end_of_text)
  );

endmodule

@@ tb/sfr_text_checker.sv @@
`timescale 1ns / 100ps

module sfr_text_checker #(
  parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        out_byte_valid,
  input  logic        out_end_of_text,
  output int          mismatches,
  output int          backlog,
  output int          results_seen
);
  import sfr_pkg::*;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       carries_byte;
    logic       last_of_text;
  } text_char_t;

  text_char_t  expected_text[$];

  logic [63:0] pat_bytes;
  logic [3:0]  pat_len;
  logic [63:0] rep_bytes;
  logic [3:0]  rep_len;
  logic [7:0]  win [0:7];
  int unsigned fill;

  initial begin
    mismatches   = 0;
    results_seen = 0;
    backlog      = 0;
  end

  function automatic void queue_char(input logic [7:0] b, input logic carries);
    text_char_t c;
    c.text_byte    = b;
    c.carries_byte = carries;
    c.last_of_text = 1'b0;
    expected_text.push_back(c);
  endfunction

  // Work out what one accepted byte request makes the block send.
  task automatic rewrite_byte(input logic [7:0] d, input logic fin);
    int unsigned plen;
    int unsigned rlen;
    int          first;
    logic        hit;
    plen  = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
    rlen  = (rep_len > REPLACE_MAX) ? REPLACE_MAX : rep_len;
    first = expected_text.size();
    if (plen == 0) begin
      queue_char(d, 1'b1);
    end else begin
      if (fill > 7) fill = 7;
      win[fill] = d;
      fill++;
      if (fill >= plen) begin
        hit = 1'b1;
        for (int i = 0; i < plen; i++)
          if (win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          for (int i = 0; i < rlen; i++) queue_char(rep_bytes[8*i +: 8], 1'b1);
          fill = 0;
        end else begin
          queue_char(win[0], 1'b1);
          for (int i = 0; i < 7; i++) win[i] = win[i+1];
          fill--;
        end
      end
      if (fin) begin
        for (int i = 0; i < fill; i++) queue_char(win[i], 1'b1);
        fill = 0;
      end
    end
    if (fin) begin
      // Nothing to send for the last byte: a bare end marker closes the text.
      if (expected_text.size() == first) queue_char(8'h00, 1'b0);
      expected_text[expected_text.size()-1].last_of_text = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      pat_bytes = '0;
      pat_len   = '0;
      rep_bytes = '0;
      rep_len   = '0;
      fill      = 0;
      expected_text.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_BYTES:      pat_bytes = cfg_data;
          REG_PATTERN_LENGTH: begin
            pat_len = cfg_data[3:0];
            fill    = 0;
          end
          REG_REPLACEMENT_BYTES:  rep_bytes = cfg_data;
          REG_REPLACEMENT_LENGTH: rep_len   = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) rewrite_byte(in_data_byte, in_final_byte);
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_text.size() == 0) begin
          $error("unexpected result: out_byte %0h byte_valid %0b end_of_text %0b",
                 out_byte, out_byte_valid, out_end_of_text);
          mismatches++;
        end else begin
          want = expected_text.pop_front();
          if (out_byte !== want.text_byte) begin
            $error("out_byte: expected %0h, got %0h", want.text_byte, out_byte);
            mismatches++;
          end
          if (out_byte_valid !== want.carries_byte) begin
            $error("byte_valid: expected %0b, got %0b", want.carries_byte, out_byte_valid);
            mismatches++;
          end
          if (out_end_of_text !== want.last_of_text) begin
            $error("end_of_text: expected %0b, got %0b", want.last_of_text,
                   out_end_of_text);
            mismatches++;
          end
        end
      end
    end
    backlog <= expected_text.size();
  end

endmodule

@@ tb/stream_find_and_replace_tb.sv @@
`timescale 1ns / 100ps

module stream_find_and_replace_tb;
  import sfr_pkg::*;

  // Cycles to let pass after the last expected result before touching config
  // or ending; requests that leave nothing behind never enter the two-deep
  // bundle queue.
  localparam int SETTLE       = 10;
  localparam int RANDOM_BYTES = 140;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index       = '0;
  logic [63:0] cfg_data        = '0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte    = '0;
  logic        in_final_byte   = 1'b0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_end_of_text;

  int mismatches;
  int backlog;
  int results_seen;

  // Stall bounds for each side; zero gives a stretch with no idling.
  int unsigned tx_gap_max  = 5;
  int unsigned rx_stall_max = 5;
  int unsigned rx_hold     = 0;

  int requests_sent = 0;
  int texts_closed  = 0;
  int reg_writes    = 0;
  int phases_run    = 0;

  logic [7:0] text_q[$];

  stream_find_and_replace uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_final_byte   (in_final_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_end_of_text (out_end_of_text)
  );

  sfr_text_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_final_byte   (in_final_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_end_of_text (out_end_of_text),
    .mismatches      (mismatches),
    .backlog         (backlog),
    .results_seen    (results_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: after each accepted result, drop ready for a drawn number of
  // cycles, then raise it and hold it until the next result goes through.
  always @(posedge clk) begin : rx_side
    int unsigned hold;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else if (out_valid && out_ready) begin
      hold = $urandom_range(0, rx_stall_max);
      rx_hold   <= hold;
      out_ready <= (hold == 0);
    end else if (rx_hold > 1) begin
      rx_hold <= rx_hold - 1;
    end else begin
      rx_hold   <= 0;
      out_ready <= 1'b1;
    end
  end

  // Hold valid and payload until the request is taken. Valid stays high
  // between back-to-back requests; it only drops for a drawn gap.
  task automatic send_byte(input logic [7:0] d, input logic fin);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= d;
    in_final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // Send text_q; mark the last byte final only when the text is to be closed.
  task automatic send_text(input logic close_text);
    for (int i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], close_text && (i == text_q.size() - 1));
    if (close_text) texts_closed++;
  endtask

  // Drop the input, wait for every expected result, then let the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input sfr_reg_t idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
  endtask

  // Write the registers selected by mask; the block must be idle here.
  task automatic program_regs(input logic [3:0] mask, input logic [63:0] pat,
                              input logic [3:0] plen, input logic [63:0] rep,
                              input logic [3:0] rlen);
    wait_idle();
    if (mask[REG_PATTERN_BYTES])      put_reg(REG_PATTERN_BYTES, pat);
    if (mask[REG_PATTERN_LENGTH])     put_reg(REG_PATTERN_LENGTH, {60'd0, plen});
    if (mask[REG_REPLACEMENT_BYTES])  put_reg(REG_REPLACEMENT_BYTES, rep);
    if (mask[REG_REPLACEMENT_LENGTH]) put_reg(REG_REPLACEMENT_LENGTH, {60'd0, rlen});
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0]  syms [0:3];
    logic [63:0] pat;
    logic [63:0] rep;
    logic [3:0]  plen;
    logic [3:0]  rlen;
    logic [3:0]  mask;
    int unsigned plen_eff;
    int unsigned text_len;
    int unsigned n_texts;
    int unsigned pick;
    int unsigned cut;
    int          random_start;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty pattern after reset: bytes pass straight through.
    text_q = '{8'h00, 8'hFF};
    send_text(1'b1);

    // Two-byte pattern, three-byte replacement; junk above the pattern length
    // must be ignored. Covers a hit, a miss and an overlapping retry.
    program_regs(4'hF, 64'hFFFF_FFFF_FFFF_6261, 4'd2, 64'h0000_0000_005A_5958, 4'd3);
    text_q = '{8'h61, 8'h62, 8'h63, 8'h61, 8'h61, 8'h62};
    send_text(1'b1);

    // Oversized lengths clamp to eight: full-width pattern and replacement.
    program_regs(4'hF, 64'hFF07_0605_0403_0201, 4'hF, 64'hFFEE_DDCC_BBAA_9988, 4'hF);
    text_q = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'hFF};
    send_text(1'b1);

    // Null-byte pattern, empty replacement: the final byte completes a hit that
    // sends nothing, so only a bare end marker comes out.
    program_regs(4'b1011, 64'h0, 4'd2, 64'h0, 4'd0);
    text_q = '{8'h00, 8'h00};
    send_text(1'b1);

    // Mid-text rewrites: new pattern bytes keep the held bytes, a pattern
    // length write drops them.
    program_regs(4'hF, 64'h0063_6261, 4'd3, 64'h51, 4'd1);
    text_q = '{8'h61, 8'h62};
    send_text(1'b0);
    program_regs(4'b0001, 64'h0064_6261, 4'd0, 64'h0, 4'd0);
    text_q = '{8'h64, 8'h61};
    send_text(1'b0);
    program_regs(4'b0010, 64'h0, 4'd3, 64'h0, 4'd0);
    text_q = '{8'h7A};
    send_text(1'b1);
    phases_run = 5;

    // Random phases: texts mostly built from a small alphabet with pattern
    // copies and broken prefixes dropped in, plus some fully random bytes.
    random_start = requests_sent;
    while (requests_sent - random_start < RANDOM_BYTES) begin
      tx_gap_max   = $urandom_range(0, 1) * 5;
      rx_stall_max = $urandom_range(0, 1) * 5;
      for (int i = 0; i < 4; i++) syms[i] = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      if (pick == 0)     plen = 4'd0;
      else if (pick < 8) plen = 4'($urandom_range(1, 4));
      else               plen = 4'($urandom_range(5, 15));
      plen_eff = (plen > 8) ? 8 : plen;
      pat = {$urandom, $urandom};
      for (int i = 0; i < 8; i++) pat[8*i +: 8] = syms[$urandom_range(0, 3)];
      rep  = {$urandom, $urandom};
      rlen = 4'($urandom_range(0, 15));
      mask = (phases_run == 5) ? 4'hF : 4'($urandom_range(1, 15));
      program_regs(mask, pat, plen, rep, rlen);
      phases_run++;

      n_texts = $urandom_range(1, 4);
      for (int t = 0; t < n_texts; t++) begin
        text_len = $urandom_range(1, 14);
        text_q.delete();
        while (text_q.size() < text_len) begin
          pick = $urandom_range(0, 9);
          if (pick < 3 && plen_eff > 0) begin
            for (int i = 0; i < plen_eff; i++) text_q.push_back(pat[8*i +: 8]);
          end else if (pick == 3 && plen_eff > 1) begin
            cut = $urandom_range(1, plen_eff - 1);
            for (int i = 0; i < cut; i++) text_q.push_back(pat[8*i +: 8]);
          end else if (pick == 4) begin
            text_q.push_back(8'($urandom_range(0, 255)));
          end else begin
            text_q.push_back(syms[$urandom_range(0, 3)]);
          end
        end
        // Leave the last text of a phase open now and then, so the next
        // register writes land mid-text.
        send_text((t != n_texts - 1) || ($urandom_range(0, 2) != 0));
      end
    end

    wait_idle();
    $display("Sent %0d byte requests over %0d phases, %0d texts closed, %0d register writes.",
             requests_sent, phases_run, texts_closed, reg_writes);
    $display("Checked %0d results against the predicted text.", results_seen);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout: %0d results still expected.", backlog);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
